/* rtl/dblm_pkg.sv */
// Shared types and constants of the derivative line minimizer.
`default_nettype none
package dblm_pkg;

	typedef logic signed [39:0] wide_t;
	typedef logic signed [31:0] q32_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	localparam logic [1:0] ST_EVAL      = 2'd0;
	localparam logic [1:0] ST_CONVERGED = 2'd1;
	localparam logic [1:0] ST_EARLY     = 2'd2;
	localparam logic [1:0] ST_ITER_LIM  = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_TRIAL = 2'd2;

	localparam logic [2:0] CFG_FIRST_END  = 3'd0;
	localparam logic [2:0] CFG_MIDDLE     = 3'd1;
	localparam logic [2:0] CFG_SECOND_END = 3'd2;
	localparam logic [2:0] CFG_ACCURACY   = 3'd3;
	localparam logic [2:0] CFG_ES_ENABLE  = 3'd4;
	localparam logic [2:0] CFG_ES_LEVEL   = 3'd5;

	localparam logic [30:0] ACCURACY_RESET = 31'd66;

	// secant step limit, 2^34
	localparam logic [34:0] SEC_CLAMP = 35'h4_0000_0000;

	typedef struct packed {
		logic               start;
		logic signed [32:0] span;
		logic signed [31:0] dx;
		logic signed [32:0] den;
	} sec_req_t;

	typedef struct packed {
		logic               done;
		logic signed [35:0] q;
	} sec_rsp_t;

	function automatic wide_t abs_w(input wide_t v);
		return v[39] ? -v : v;
	endfunction

	// halve, truncating toward zero
	function automatic wide_t half_w(input wide_t v);
		wide_t t;
		t = v + {39'b0, v[39]};
		return t >>> 1;
	endfunction

	function automatic q32_t sat32(input wide_t v);
		if (v > 40'sh00_7fff_ffff) return 32'sh7fff_ffff;
		if (v < -40'sh00_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/dblm_if.sv */
// Request and result channel interfaces.
`default_nettype none
interface dblm_cmd_if;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic signed [31:0] func_value;
	logic signed [31:0] deriv_value;
	modport source(output valid, opcode, func_value, deriv_value, input ready);
	modport sink(input valid, opcode, func_value, deriv_value, output ready);
endinterface

interface dblm_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [31:0] point;
	logic signed [31:0] point_value;
	modport source(output valid, status, point, point_value, input ready);
	modport sink(input valid, status, point, point_value, output ready);
endinterface
`default_nettype wire

/* rtl/dblm_secant.sv */
// Serial secant unit: shift-add multiply then restoring divide, clamped.
`default_nettype none
module dblm_secant (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dblm_pkg::sec_req_t req,
	output dblm_pkg::sec_rsp_t      rsp
);
	import dblm_pkg::*;

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_MUL  = 3'd1;
	localparam logic [2:0] U_PRE  = 3'd2;
	localparam logic [2:0] U_DIV  = 3'd3;
	localparam logic [2:0] U_DONE = 3'd4;

	logic [2:0]  st_q;
	logic [5:0]  cnt_q;
	logic        neg_q, sat_q;
	logic [63:0] mc_q, acc_q;
	logic [31:0] mp_q;
	logic [67:0] dvs_q;
	logic [34:0] qm_q;

	logic [32:0] span_mag, den_mag;
	logic [31:0] dx_mag;
	logic        ge;
	logic [34:0] mag;

	always_comb begin
		span_mag = req.span[32] ? 33'(-req.span) : 33'(req.span);
		den_mag  = req.den[32] ? 33'(-req.den) : 33'(req.den);
		dx_mag   = req.dx[31] ? 32'(-req.dx) : 32'(req.dx);
		ge       = {4'b0, acc_q} >= dvs_q;
		mag      = (sat_q || qm_q > SEC_CLAMP) ? SEC_CLAMP : qm_q;
		rsp.done = (st_q == U_DONE);
		rsp.q    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= U_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				U_IDLE: begin
					if (req.start) begin
						mc_q  <= {31'b0, span_mag};
						mp_q  <= dx_mag;
						acc_q <= '0;
						dvs_q <= {35'b0, den_mag};
						neg_q <= req.span[32] ^ req.dx[31] ^ req.den[32];
						sat_q <= 1'b0;
						cnt_q <= '0;
						st_q  <= U_MUL;
					end
				end
				U_MUL: begin
					if (mp_q[0]) acc_q <= acc_q + mc_q;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) st_q <= U_PRE;
				end
				U_PRE: begin
					// quotient of 2^35 or more saturates without dividing
					if ({4'b0, acc_q} >= (dvs_q << 35)) begin
						sat_q <= 1'b1;
						st_q  <= U_DONE;
					end else begin
						dvs_q <= dvs_q << 34;
						qm_q  <= '0;
						cnt_q <= '0;
						st_q  <= U_DIV;
					end
				end
				U_DIV: begin
					if (ge) acc_q <= acc_q - dvs_q[63:0];
					qm_q  <= {qm_q[33:0], ge};
					dvs_q <= dvs_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd34) st_q <= U_DONE;
				end
				U_DONE:  st_q <= U_IDLE;
				default: st_q <= U_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/derivative_brent_line_minimizer.sv */
// Top level: derivative-assisted Brent line minimizer with its sequencer.
// Sequence: a start request, or a reply while no search runs, is handed to the result
// register as soon as it is free; a search reply first passes the update, the convergence
// check and up to two secant runs (32 multiply steps, one range check, 35 divide steps
// unless the quotient saturates, one hand-back). Throughput: one request at a time;
// ready is high only while the sequencer waits. Reset (arst_n low, asynchronous) clears
// all search state and restores the register defaults; no clearing pass is needed.
`default_nettype none
module derivative_brent_line_minimizer #(
	parameter int ITER_LIMIT = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dblm_cmd_if.sink         cmd,
	dblm_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import dblm_pkg::*;

	localparam int IW = $clog2(ITER_LIMIT + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_REPLY = 4'd1;
	localparam logic [3:0] S_P0    = 4'd2;
	localparam logic [3:0] S_P1    = 4'd3;
	localparam logic [3:0] S_S1    = 4'd4;
	localparam logic [3:0] S_S2    = 4'd5;
	localparam logic [3:0] S_S2W   = 4'd6;
	localparam logic [3:0] S_CH    = 4'd7;
	localparam logic [3:0] S_EDGE  = 4'd8;
	localparam logic [3:0] S_BIS   = 4'd9;
	localparam logic [3:0] S_TRY   = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	// configuration
	q32_t        bfe_q, bmid_q, bse_q, es_lvl_q;
	logic [30:0] tol_q;
	logic        es_en_q;

	// search state
	q32_t lo_q, hi_q, x_q, p2_q, p3_q, v1_q, v2_q, v3_q, s1_q, s2_q, s3_q;
	q32_t prior_q, latest_q, trial_q;
	logic [IW-1:0] iter_q;
	logic [1:0]    phase_q;
	logic          minimal_q;

	// working registers
	logic [3:0]  st_q;
	q32_t        fv_q, dv_q;
	wide_t       xm_q, thr_q, olde_q, d1_q, d2_q, dsel_q, d_q;
	logic [1:0]  rst_q;
	q32_t        rpt_q, rval_q;

	// result register
	logic        o_valid_q;
	logic [1:0]  o_status_q;
	q32_t        o_point_q, o_value_q;

	sec_req_t sreq;
	sec_rsp_t sres;

	dblm_secant u_sec (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(sres));

	wide_t a, b, x, dx, tol1, tol2, ws1, ws2, u1, u2, dch, ue, e, dt, ut;
	logic  early, ok1, ok2, take, conv, minimal;
	logic [IW-1:0] iter_nx;

	assign cmd.ready       = (st_q == S_IDLE);
	assign rsp.valid       = o_valid_q;
	assign rsp.status      = o_status_q;
	assign rsp.point       = o_point_q;
	assign rsp.point_value = o_value_q;

	always_comb begin
		a    = wide_t'(lo_q);
		b    = wide_t'(hi_q);
		x    = wide_t'(x_q);
		dx   = wide_t'(s1_q);
		tol1 = wide_t'({9'b0, tol_q});
		tol2 = tol1 <<< 1;
		early = es_en_q && (fv_q < es_lvl_q);
		iter_nx = iter_q + IW'(1);
		conv = abs_w(x - xm_q) <= thr_q;
		ws1  = wide_t'(s2_q);
		ws2  = wide_t'(s3_q);
		// secant candidates: inside the bracket and heading against the slope
		u1  = x + d1_q;
		u2  = x + d2_q;
		ok1 = u1 > a && u1 < b &&
			(dx == 0 || d1_q == 0 || (dx[39] != d1_q[39]));
		ok2 = u2 > a && u2 < b &&
			(dx == 0 || d2_q == 0 || (dx[39] != d2_q[39]));
		if (ok1 && ok2) dch = (abs_w(d1_q) < abs_w(d2_q)) ? d1_q : d2_q;
		else dch = ok1 ? d1_q : d2_q;
		take = (ok1 || ok2) && (abs_w(dch) <= abs_w(half_w(olde_q)));
		ue  = x + dsel_q;
		e   = (dx >= 0) ? a - x : b - x;
		dt  = wide_t'(sat32(d_q));
		minimal = abs_w(dt) < tol1;
		if (!minimal) ut = x + dt;
		else ut = x + ((dt >= 0) ? tol1 : -tol1);

		sreq = '0;
		if (st_q == S_P1 && !conv && abs_w(wide_t'(prior_q)) > tol1 && s2_q != s1_q) begin
			sreq.start = 1'b1;
			sreq.span  = 33'(wide_t'(p2_q) - x);
			sreq.den   = 33'(dx - ws1);
		end else if (st_q == S_S2 && s3_q != s1_q) begin
			sreq.start = 1'b1;
			sreq.span  = 33'(wide_t'(p3_q) - x);
			sreq.den   = 33'(dx - ws2);
		end
		sreq.dx = s1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bfe_q     <= '0;
			bmid_q    <= '0;
			bse_q     <= '0;
			tol_q     <= ACCURACY_RESET;
			es_en_q   <= 1'b0;
			es_lvl_q  <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			x_q       <= '0;
			p2_q      <= '0;
			p3_q      <= '0;
			v1_q      <= '0;
			v2_q      <= '0;
			v3_q      <= '0;
			s1_q      <= '0;
			s2_q      <= '0;
			s3_q      <= '0;
			prior_q   <= '0;
			latest_q  <= '0;
			trial_q   <= '0;
			iter_q    <= '0;
			phase_q   <= PH_IDLE;
			minimal_q <= 1'b0;
			st_q      <= S_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_END:  bfe_q    <= cfg_data;
					CFG_MIDDLE:     bmid_q   <= cfg_data;
					CFG_SECOND_END: bse_q    <= cfg_data;
					CFG_ACCURACY:   tol_q    <= cfg_data[30:0];
					CFG_ES_ENABLE:  es_en_q  <= cfg_data[0];
					CFG_ES_LEVEL:   es_lvl_q <= cfg_data;
					default: ;
				endcase
			end

			// in S_EMIT a taken result is always replaced below
			if (rsp.ready && st_q != S_EMIT) o_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						fv_q <= cmd.func_value;
						dv_q <= cmd.deriv_value;
						if (cmd.opcode == OP_START) begin
							lo_q      <= (bfe_q < bse_q) ? bfe_q : bse_q;
							hi_q      <= (bfe_q > bse_q) ? bfe_q : bse_q;
							x_q       <= bmid_q;
							p2_q      <= bmid_q;
							p3_q      <= bmid_q;
							prior_q   <= '0;
							latest_q  <= '0;
							iter_q    <= '0;
							minimal_q <= 1'b0;
							trial_q   <= bmid_q;
							phase_q   <= PH_FIRST;
							rst_q     <= ST_EVAL;
							rpt_q     <= bmid_q;
							rval_q    <= '0;
							st_q      <= S_EMIT;
						end else if (phase_q == PH_IDLE) begin
							rst_q  <= ST_CONVERGED;
							rpt_q  <= x_q;
							rval_q <= v1_q;
							st_q   <= S_EMIT;
						end else begin
							st_q <= S_REPLY;
						end
					end
				end
				S_REPLY: begin
					if (phase_q == PH_FIRST) begin
						v1_q <= fv_q;
						v2_q <= fv_q;
						v3_q <= fv_q;
						if (early) begin
							phase_q <= PH_IDLE;
							rst_q   <= ST_EARLY;
							rpt_q   <= x_q;
							rval_q  <= fv_q;
							st_q    <= S_EMIT;
						end else begin
							s1_q <= dv_q;
							s2_q <= dv_q;
							s3_q <= dv_q;
							st_q <= S_P0;
						end
					end else if (early) begin
						phase_q <= PH_IDLE;
						rst_q   <= ST_EARLY;
						rpt_q   <= trial_q;
						rval_q  <= fv_q;
						st_q    <= S_EMIT;
					end else if (minimal_q && fv_q > v1_q) begin
						// a minimal step made things worse: settle on the best point
						phase_q <= PH_IDLE;
						rst_q   <= ST_CONVERGED;
						rpt_q   <= x_q;
						rval_q  <= v1_q;
						st_q    <= S_EMIT;
					end else begin
						if (fv_q <= v1_q) begin
							if (trial_q >= x_q) lo_q <= x_q;
							else hi_q <= x_q;
							p3_q <= p2_q; v3_q <= v2_q; s3_q <= s2_q;
							p2_q <= x_q;  v2_q <= v1_q; s2_q <= s1_q;
							x_q  <= trial_q; v1_q <= fv_q; s1_q <= dv_q;
						end else begin
							if (trial_q < x_q) lo_q <= trial_q;
							else hi_q <= trial_q;
							if (fv_q <= v2_q || p2_q == x_q) begin
								p3_q <= p2_q; v3_q <= v2_q; s3_q <= s2_q;
								p2_q <= trial_q; v2_q <= fv_q; s2_q <= dv_q;
							end else if (fv_q < v3_q || p3_q == x_q || p3_q == p2_q) begin
								p3_q <= trial_q; v3_q <= fv_q; s3_q <= dv_q;
							end
						end
						iter_q <= iter_nx;
						if (iter_nx >= IW'(ITER_LIMIT)) begin
							phase_q <= PH_IDLE;
							rst_q   <= ST_ITER_LIM;
							// best point after the update above
							rpt_q   <= (fv_q <= v1_q) ? trial_q : x_q;
							rval_q  <= (fv_q <= v1_q) ? fv_q : v1_q;
							st_q    <= S_EMIT;
						end else begin
							st_q <= S_P0;
						end
					end
				end
				S_P0: begin
					xm_q  <= half_w(a + b);
					thr_q <= tol2 - half_w(b - a);
					st_q  <= S_P1;
				end
				S_P1: begin
					olde_q <= wide_t'(prior_q);
					d1_q   <= (b - a) <<< 1;
					d2_q   <= (b - a) <<< 1;
					if (conv) begin
						phase_q <= PH_IDLE;
						rst_q   <= ST_CONVERGED;
						rpt_q   <= x_q;
						rval_q  <= v1_q;
						st_q    <= S_EMIT;
					end else if (abs_w(wide_t'(prior_q)) > tol1) begin
						st_q <= (s2_q != s1_q) ? S_S1 : S_S2;
					end else begin
						st_q <= S_BIS;
					end
				end
				S_S1: begin
					if (sres.done) begin
						d1_q <= wide_t'(sres.q);
						st_q <= S_S2;
					end
				end
				S_S2: st_q <= (s3_q != s1_q) ? S_S2W : S_CH;
				S_S2W: begin
					if (sres.done) begin
						d2_q <= wide_t'(sres.q);
						st_q <= S_CH;
					end
				end
				S_CH: begin
					prior_q <= latest_q;
					dsel_q  <= dch;
					st_q    <= take ? S_EDGE : S_BIS;
				end
				S_EDGE: begin
					// too close to a bracket end: step by the tolerance instead
					if (ue - a < tol2 || b - ue < tol2)
						d_q <= (xm_q - x >= 0) ? tol1 : -tol1;
					else
						d_q <= dsel_q;
					st_q <= S_TRY;
				end
				S_BIS: begin
					prior_q <= sat32(e);
					d_q     <= half_w(e);
					st_q    <= S_TRY;
				end
				S_TRY: begin
					latest_q  <= dt[31:0];
					minimal_q <= minimal;
					trial_q   <= sat32(ut);
					phase_q   <= PH_TRIAL;
					rst_q     <= ST_EVAL;
					rpt_q     <= sat32(ut);
					rval_q    <= '0;
					st_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (!o_valid_q || rsp.ready) begin
						o_valid_q  <= 1'b1;
						o_status_q <= rst_q;
						o_point_q  <= rpt_q;
						o_value_q  <= rval_q;
						st_q       <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// the secant unit answers only while the sequencer waits for it
	a_sec_done: assert property (@(posedge clk) disable iff (!arst_n)
		sres.done |-> (st_q == S_S1 || st_q == S_S2W))
		else $error("secant result outside a wait state");

	// a running search never sits at or past the iteration limit
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRIAL) |-> (iter_q < IW'(ITER_LIMIT)))
		else $error("iteration count beyond limit in a running search");

	// a finish status always leaves the search idle
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT && rst_q != ST_EVAL) |-> (phase_q == PH_IDLE))
		else $error("finish reported with search still running");
`endif
endmodule
`default_nettype wire

/* tb/sv/dblm_checker.sv */
// Checker: watches both channels and the register port, predicts each result and compares.
module dblm_checker (
	input  logic        clk,
	input  logic        arst_n,
	dblm_cmd_if         cmd,
	dblm_rsp_if         rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dblm_pkg::*;

	localparam int ITER_CAP = 100;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] point;
		logic [31:0] pval;
	} res_t;

	res_t expected_q[$];

	// register copies
	longint cf_end0, cf_mid, cf_end1, cf_tol, cf_es_en, cf_es_lvl;
	// search state
	longint lo_b, hi_b, pos0, pos1, pos2, val0, val1, val2, slp0, slp1, slp2;
	longint step_prev, step_last, trial;
	int unsigned iter;
	logic [1:0] ph;
	bit tiny_step;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint secant_step(longint span, longint dx, longint den);
		longint q;
		longint lim;
		lim = longint'(1) <<< 34;
		q = (span * dx) / den;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		return q;
	endfunction

	function automatic bit fits(longint a, longint b, longint x, longint dx, longint dd);
		longint u;
		bit opp;
		u = x + dd;
		opp = (dx == 0) || (dd == 0) || ((dx < 0) != (dd < 0));
		return (u > a) && (u < b) && opp;
	endfunction

	function automatic res_t mk(logic [1:0] st, longint p, longint v);
		res_t r;
		r.status = st;
		r.point  = p[31:0];
		r.pval   = v[31:0];
		return r;
	endfunction

	// convergence test, then choice of the next trial point
	function automatic res_t next_trial();
		longint a, b, x, dx, tol1, tol2, xm, d, u, d1, d2, olde, e;
		bit bis, ok1, ok2;
		a = lo_b; b = hi_b; x = pos0; dx = slp0;
		tol1 = cf_tol; tol2 = 2 * tol1;
		xm = (a + b) / 2;
		d = 0;
		bis = 1;
		if (mag(x - xm) <= tol2 - (b - a) / 2) begin
			ph = PH_IDLE;
			return mk(ST_CONVERGED, x, val0);
		end
		if (mag(step_prev) > tol1) begin
			d1 = 2 * (b - a);
			d2 = d1;
			olde = step_prev;
			if (slp1 != dx) d1 = secant_step(pos1 - x, dx, dx - slp1);
			if (slp2 != dx) d2 = secant_step(pos2 - x, dx, dx - slp2);
			ok1 = fits(a, b, x, dx, d1);
			ok2 = fits(a, b, x, dx, d2);
			step_prev = step_last;
			if (ok1 || ok2) begin
				if (ok1 && ok2) d = (mag(d1) < mag(d2)) ? d1 : d2;
				else d = ok1 ? d1 : d2;
				if (mag(d) <= mag(olde / 2)) begin
					bis = 0;
					u = x + d;
					if (u - a < tol2 || b - u < tol2) d = (xm - x >= 0) ? tol1 : -tol1;
				end
			end
		end
		if (bis) begin
			e = (dx >= 0) ? a - x : b - x;
			step_prev = clip32(e);
			d = e / 2;
		end
		d = clip32(d);
		step_last = d;
		if (mag(d) >= tol1) begin
			u = x + d;
			tiny_step = 0;
		end else begin
			u = x + ((d >= 0) ? tol1 : -tol1);
			tiny_step = 1;
		end
		trial = clip32(u);
		ph = PH_TRIAL;
		return mk(ST_EVAL, trial, 0);
	endfunction

	function automatic res_t predict(logic op, longint fv, longint dv);
		bit early;
		longint u;
		if (op == OP_START) begin
			lo_b = (cf_end0 < cf_end1) ? cf_end0 : cf_end1;
			hi_b = (cf_end0 > cf_end1) ? cf_end0 : cf_end1;
			pos0 = cf_mid; pos1 = cf_mid; pos2 = cf_mid;
			step_prev = 0; step_last = 0;
			iter = 0;
			tiny_step = 0;
			trial = cf_mid;
			ph = PH_FIRST;
			return mk(ST_EVAL, cf_mid, 0);
		end
		if (ph == PH_IDLE) return mk(ST_CONVERGED, pos0, val0);
		early = (cf_es_en != 0) && (fv < cf_es_lvl);
		if (ph == PH_FIRST) begin
			val0 = fv; val1 = fv; val2 = fv;
			if (early) begin
				ph = PH_IDLE;
				return mk(ST_EARLY, pos0, fv);
			end
			slp0 = dv; slp1 = dv; slp2 = dv;
			return next_trial();
		end
		u = trial;
		if (early) begin
			ph = PH_IDLE;
			return mk(ST_EARLY, u, fv);
		end
		if (tiny_step && fv > val0) begin
			ph = PH_IDLE;
			return mk(ST_CONVERGED, pos0, val0);
		end
		if (fv <= val0) begin
			if (u >= pos0) lo_b = pos0; else hi_b = pos0;
			pos2 = pos1; val2 = val1; slp2 = slp1;
			pos1 = pos0; val1 = val0; slp1 = slp0;
			pos0 = u; val0 = fv; slp0 = dv;
		end else begin
			if (u < pos0) lo_b = u; else hi_b = u;
			if (fv <= val1 || pos1 == pos0) begin
				pos2 = pos1; val2 = val1; slp2 = slp1;
				pos1 = u; val1 = fv; slp1 = dv;
			end else if (fv < val2 || pos2 == pos0 || pos2 == pos1) begin
				pos2 = u; val2 = fv; slp2 = dv;
			end
		end
		iter = (iter + 1) & 32'h7f;
		if (iter >= ITER_CAP) begin
			ph = PH_IDLE;
			return mk(ST_ITER_LIM, pos0, val0);
		end
		return next_trial();
	endfunction

	task automatic mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			cf_end0 = 0; cf_mid = 0; cf_end1 = 0;
			cf_tol = longint'(ACCURACY_RESET); cf_es_en = 0; cf_es_lvl = 0;
			lo_b = 0; hi_b = 0; pos0 = 0; pos1 = 0; pos2 = 0;
			val0 = 0; val1 = 0; val2 = 0; slp0 = 0; slp1 = 0; slp2 = 0;
			step_prev = 0; step_last = 0; trial = 0;
			iter = 0; ph = PH_IDLE; tiny_step = 0;
			expected_q.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_END:  cf_end0 = longint'($signed(cfg_data));
					CFG_MIDDLE:     cf_mid = longint'($signed(cfg_data));
					CFG_SECOND_END: cf_end1 = longint'($signed(cfg_data));
					CFG_ACCURACY:   cf_tol = longint'({33'b0, cfg_data[30:0]});
					CFG_ES_ENABLE:  cf_es_en = longint'(cfg_data[0]);
					CFG_ES_LEVEL:   cf_es_lvl = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				expected_q.push_back(predict(cmd.opcode, longint'(cmd.func_value),
					longint'(cmd.deriv_value)));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					mismatch("unexpected result, point", rsp.point, 32'h0);
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status)
						mismatch("status", {30'b0, rsp.status}, {30'b0, want.status});
					if (rsp.point !== want.point) mismatch("point", rsp.point, want.point);
					if (rsp.point_value !== want.pval)
						mismatch("point_value", rsp.point_value, want.pval);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

/* tb/sv/derivative_brent_line_minimizer_tb.sv */
// Testbench top: drives searches and register settings into the minimizer, gives the verdict.
module derivative_brent_line_minimizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dblm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fails;
	int          pending;

	dblm_cmd_if cmd();
	dblm_rsp_if rsp();

	derivative_brent_line_minimizer u_dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dblm_checker u_check (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always #4 clk = ~clk;

	// shadow of the bracket registers, used to place the minimum of the test function
	longint br_end0, br_mid, br_end1;
	bit     calm = 0;      // no idling on either side
	bit     hold_req = 0;  // ask the receiver for one long hold-off
	bit     held = 0;      // the long hold-off has been run
	int     sent = 0;

	typedef struct {
		logic [1:0]  status;
		logic signed [31:0] point;
	} seen_t;
	seen_t seen_q[$];

	// results as the stimulus side sees them, to choose the next reply
	always @(posedge clk)
		if (rsp.valid && rsp.ready) seen_q.push_back('{rsp.status, rsp.point});

	// receiver: random stalls in bursts, one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp.ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = $urandom;
	endtask

	// one request: optional gap, offer, wait for the handshake, withdraw
	task automatic send(input logic op, input logic [31:0] fv, input logic [31:0] dv);
		if (!calm && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 15)) @(negedge clk);
		@(negedge clk);
		cmd.valid = 1'b1;
		cmd.opcode = op;
		cmd.func_value = fv;
		cmd.deriv_value = dv;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		cmd.valid = 1'b0;
		sent++;
	endtask

	task automatic await_result(output seen_t r);
		while (seen_q.size() == 0) @(posedge clk);
		r = seen_q.pop_front();
	endtask

	// block idle: all results in, then a margin for any work still in flight
	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (5) @(negedge clk);
		seen_q.delete();
	endtask

	task automatic set_bracket(input longint e0, input longint m, input longint e1);
		br_end0 = e0; br_mid = m; br_end1 = e1;
		write_reg(CFG_FIRST_END, e0[31:0]);
		write_reg(CFG_MIDDLE, m[31:0]);
		write_reg(CFG_SECOND_END, e1[31:0]);
	endtask

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// random register setting; small brackets mostly, extremes now and then
	task automatic reconfigure();
		longint c, w, e0, e1, m;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			e0 = -64'sd2147483648; e1 = 64'sd2147483647;
			m = longint'($signed($urandom));
		end else begin
			c = longint'($signed($urandom)) >>> 8;
			w = $urandom_range(1, 1 << 20);
			e0 = c - longint'($urandom_range(0, w));
			e1 = c + longint'($urandom_range(0, w));
			m = e0 + longint'($urandom_range(0, 32'(e1 - e0)));
			if (pick == 1) m = e1 + 1000;   // start point outside the bracket
			if ($urandom_range(0, 1)) begin
				c = e0; e0 = e1; e1 = c;
			end
		end
		set_bracket(e0, m, e1);
		case ($urandom_range(0, 9))
			0:       write_reg(CFG_ACCURACY, {$urandom_range(0, 1) == 1, 31'd0});
			1:       write_reg(CFG_ACCURACY, {$urandom_range(0, 1) == 1, 31'h7fff_ffff});
			default: write_reg(CFG_ACCURACY, {1'b0, 31'($urandom_range(1, 300))});
		endcase
		write_reg(CFG_ES_ENABLE, {31'($urandom), $urandom_range(0, 3) == 0});
		write_reg(CFG_ES_LEVEL, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4000)));
	endtask

	// test function: scaled parabola about a minimum, slope of the unscaled parabola, with an offset
	task automatic parabola(input longint p, input longint low, input longint off,
			output logic [31:0] fv, output logic [31:0] dv);
		longint diff, h;
		diff = p - low;
		h = diff >>> 8;
		fv = clip32(h * h + off);
		dv = clip32(2 * diff);
	endtask

	// kind 0: well-formed parabola search; 1: random replies; 2: abandoned by a new start
	task automatic run_search(input int kind, input int max_replies);
		seen_t r;
		longint lo, hi, low, off;
		logic [31:0] fv, dv;
		int n;
		lo = (br_end0 < br_end1) ? br_end0 : br_end1;
		hi = (br_end0 < br_end1) ? br_end1 : br_end0;
		low = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
		off = longint'($signed($urandom)) >>> $urandom_range(4, 20);
		send(OP_START, $urandom, $urandom);
		await_result(r);
		n = 0;
		while (r.status == ST_EVAL && n < max_replies) begin
			if (kind == 0) parabola(longint'(r.point), low, off, fv, dv);
			else begin
				fv = $urandom;
				dv = $urandom;
			end
			send(OP_REPLY, fv, dv);
			await_result(r);
			n++;
		end
		if (kind == 2) begin
			send(OP_START, $urandom, $urandom);
			await_result(r);
		end
	endtask

	initial begin
		int kind;
		cmd.valid = 1'b0;
		cmd.opcode = OP_START;
		cmd.func_value = '0;
		cmd.deriv_value = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		br_end0 = 0; br_mid = 0; br_end1 = 0;

		// --- directed ---
		// replies with nothing running: converged at the reset point
		send(OP_REPLY, 32'h7fff_ffff, 32'h8000_0000);
		send(OP_REPLY, 32'h8000_0000, 32'h7fff_ffff);
		// reset bracket is a single point: converges on the first reply
		run_search(0, 5);
		send(OP_REPLY, 32'h0, 32'hffff_ffff);
		settle();
		// widest bracket, parabola
		set_bracket(-64'sd2147483648, 64'sd0, 64'sd2147483647);
		write_reg(CFG_ACCURACY, 32'd1);
		run_search(0, 120);
		settle();
		// early stop on the first reply, then a short search with a level no value falls below
		write_reg(CFG_ES_ENABLE, 32'd1);
		write_reg(CFG_ES_LEVEL, 32'h7fff_ffff);
		run_search(1, 1);
		settle();
		write_reg(CFG_ES_LEVEL, 32'h8000_0000);
		run_search(0, 2);
		settle();
		write_reg(CFG_ES_ENABLE, 32'd0);
		// no tolerance and random replies: long runs toward the iteration limit
		write_reg(CFG_ACCURACY, 32'd0);
		run_search(1, 110);
		settle();
		// largest tolerance, and a search abandoned by a new start
		write_reg(CFG_ACCURACY, 32'hffff_ffff);
		run_search(2, 3);
		settle();

		// --- random ---
		while (sent < 700) begin
			calm = (sent > 600);
			if ($urandom_range(0, 2) == 0) begin
				settle();
				reconfigure();
			end
			if (sent > 250 && !held && !calm) begin
				// long receiver hold-off while requests keep coming
				settle();
				held = 1;
				hold_req = 1;
				repeat (6) send($urandom_range(0, 1), $urandom, $urandom);
				settle();
			end
			kind = $urandom_range(0, 9);
			if (kind < 7) run_search(0, 110);
			else if (kind < 9) run_search(1, 110);
			else run_search(2, $urandom_range(0, 6));
			if ($urandom_range(0, 7) == 0) begin
				settle();
				send(OP_REPLY, $urandom, $urandom);
			end
		end

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/dblm_pkg.sv
rtl/dblm_if.sv
rtl/dblm_secant.sv
rtl/derivative_brent_line_minimizer.sv
tb/sv/dblm_checker.sv
tb/sv/derivative_brent_line_minimizer_tb.sv
